### sv/asks_pkg.sv
// ----------------------------------------------------------------------------
// asks_pkg
// Types, codes and fixed-point helpers shared by the key shader pipeline.
// ----------------------------------------------------------------------------
package asks_pkg;

    localparam int BAND_COUNT_DEF = 16;
    localparam int BAND_IDX_W     = 6;     // holds an index for the largest store
    localparam int RECIP_SHIFT    = 26;
    localparam int RECIP_W        = 27;

    localparam logic [15:0] ONE        = 16'd32768;
    localparam logic [15:0] FLASH_KEEP = 16'd25559;   // 0.78
    localparam logic [15:0] FLASH_MIN  = 16'd328;     // 0.01
    localparam logic [15:0] HUE_SPAN   = 16'd27197;   // 0.83
    localparam logic [15:0] GLOW_GAIN  = 16'd8192;    // 0.25

    localparam logic [1:0] MODE_BAND   = 2'd0;
    localparam logic [1:0] MODE_FRAME  = 2'd1;
    localparam logic [1:0] MODE_KEY    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] EFF_BARS    = 2'd0;
    localparam logic [1:0] EFF_RAINBOW = 2'd1;
    localparam logic [1:0] EFF_LEVEL   = 2'd2;
    localparam logic [1:0] EFF_BEAT    = 2'd3;

    localparam logic [2:0] REG_EFFECT       = 3'd0;
    localparam logic [2:0] REG_LOW_COLOR    = 3'd1;
    localparam logic [2:0] REG_HIGH_COLOR   = 3'd2;
    localparam logic [2:0] REG_TOP_ROW      = 3'd3;
    localparam logic [2:0] REG_BOTTOM_ROW   = 3'd4;
    localparam logic [2:0] REG_FIRST_COLUMN = 3'd5;
    localparam logic [2:0] REG_LAST_COLUMN  = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  band_slot;
        logic [15:0] band_value;
        logic [15:0] loudness;
        logic [15:0] bass_level;
        logic [15:0] beat_counter;
        logic [15:0] key_code;
        logic [4:0]  key_row;
        logic [4:0]  key_column;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_key;
        logic [7:0]  tint_red;
        logic [7:0]  tint_green;
        logic [7:0]  tint_blue;
        logic [15:0] mix_amount;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  effect;
        logic [23:0] low_color;
        logic [23:0] high_color;
        logic [4:0]  top_row;
        logic [4:0]  bottom_row;
        logic [4:0]  first_column;
        logic [4:0]  last_column;
    } cfg_t;

    // column stage to band stage
    typedef struct packed {
        logic [1:0]            mode;
        logic [3:0]            band_slot;
        logic [15:0]           band_value;
        logic [15:0]           loudness;
        logic [15:0]           bass_level;
        logic [15:0]           beat_counter;
        logic [15:0]           key_code;
        logic [BAND_IDX_W-1:0] idx;
        logic [4:0]            rem;
        logic [RECIP_W-1:0]    rs;
        logic [15:0]           cn;
        logic [15:0]           hn;
        logic signed [6:0]     rows;
        logic signed [5:0]     drop;
    } col_item_t;

    // band stage to color stage
    typedef struct packed {
        logic [15:0]       key_code;
        logic [15:0]       band;
        logic [15:0]       cn;
        logic [15:0]       hn;
        logic signed [6:0] rows;
        logic signed [5:0] drop;
        logic [15:0]       loud;
        logic [15:0]       bass;
        logic [15:0]       flash;
        logic [15:0]       loud_sq;
        logic [15:0]       glow;
    } band_item_t;

    function automatic logic [15:0] qmul(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] p;
        p = 33'(a) * 33'(b) + 33'd16384;
        return p[30:15];
    endfunction

    function automatic logic [15:0] sat_one(input logic [15:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

endpackage

### sv/asks_col.sv
// ----------------------------------------------------------------------------
// asks_col
// Column and row geometry: band position, column and height fractions.
// ----------------------------------------------------------------------------
module asks_col #(
    parameter int BAND_COUNT = asks_pkg::BAND_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  asks_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  asks_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output asks_pkg::col_item_t result
);
    import asks_pkg::*;

    localparam int IDX_W  = $clog2(BAND_COUNT);
    localparam int NUM_W  = 5 + IDX_W;
    localparam int PROD_W = 20 + RECIP_W;
    localparam logic [1:0] H_ZERO = 2'd0;
    localparam logic [1:0] H_ONE  = 2'd1;
    localparam logic [1:0] H_DIV  = 2'd2;

    // reciprocal table, exact quotient for dividends below 2**20
    logic [RECIP_W-1:0] recip_tab [32];
    for (genvar D = 0; D < 32; D++) begin : g_recip
        if (D == 0) begin : g_zero
            assign recip_tab[D] = '0;
        end
        else begin : g_div
            localparam logic [RECIP_W-1:0] R =
                RECIP_W'(((64'd1 << RECIP_SHIFT) + D - 1) / D);
            assign recip_tab[D] = R;
        end
    end

    logic signed [5:0] off, span_raw, drop;
    logic signed [6:0] rows, rows_m1;
    logic [4:0]        span, hdiv;
    logic              left, right;
    logic [1:0]        hsel;

    always_comb
    begin
        off      = $signed({1'b0, item.key_column}) - $signed({1'b0, cfg.first_column});
        span_raw = $signed({1'b0, cfg.last_column}) - $signed({1'b0, cfg.first_column});
        span     = (span_raw < 6'sd1) ? 5'd1 : span_raw[4:0];
        left     = (off <= 6'sd0);
        right    = !left && (off[4:0] >= span);
        rows_m1  = $signed({2'b0, cfg.bottom_row}) - $signed({2'b0, cfg.top_row});
        rows     = rows_m1 + 7'sd1;
        drop     = $signed({1'b0, cfg.bottom_row}) - $signed({1'b0, item.key_row});
        hdiv     = (rows_m1 > 7'sd0) ? rows_m1[4:0] : 5'd0;
        if (rows_m1 <= 7'sd0)
            hsel = H_ZERO;
        else if (drop <= 6'sd0)
            hsel = H_ZERO;
        else if ($signed({drop[5], drop}) >= rows_m1)
            hsel = H_ONE;
        else
            hsel = H_DIV;
    end

    logic a_free, b_free, c_free;
    logic a_v_reg, b_v_reg, c_v_reg;

    assign c_free       = !c_v_reg || result_ready;
    assign b_free       = !b_v_reg || c_free;
    assign a_free       = !a_v_reg || b_free;
    assign item_ready   = a_free;
    assign result_valid = c_v_reg;

    // stage a
    in_item_t          a_item_reg;
    logic [NUM_W-1:0]  a_num_reg;
    logic [4:0]        a_off_reg, a_span_reg, a_drop_reg;
    logic [RECIP_W-1:0] a_rs_reg, a_rr_reg;
    logic              a_left_reg, a_right_reg;
    logic [1:0]        a_hsel_reg;
    logic signed [6:0] a_rows_reg;
    logic signed [5:0] a_drops_reg;

    // stage b
    in_item_t          b_item_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic [4:0]        b_span_reg;
    logic [RECIP_W-1:0] b_rs_reg;
    logic [15:0]       b_cn_reg, b_hn_reg;
    logic              b_left_reg, b_right_reg;
    logic [1:0]        b_hsel_reg;
    logic signed [6:0] b_rows_reg;
    logic signed [5:0] b_drops_reg;

    col_item_t c_item_reg;

    logic [NUM_W+RECIP_W-1:0] q_prod;
    logic [PROD_W-1:0]        cn_prod, hn_prod;
    logic [NUM_W-1:0]         idx_span, rem_full;
    col_item_t                c_item_next;

    always_comb
    begin
        q_prod  = (NUM_W+RECIP_W)'(a_num_reg) * (NUM_W+RECIP_W)'(a_rs_reg);
        cn_prod = PROD_W'({a_off_reg, 15'd0}) * PROD_W'(a_rs_reg);
        hn_prod = PROD_W'({a_drop_reg, 15'd0}) * PROD_W'(a_rr_reg);
    end

    always_comb
    begin
        idx_span = NUM_W'(b_idx_reg) * NUM_W'(b_span_reg);
        rem_full = b_num_reg - idx_span;
        c_item_next.mode         = b_item_reg.mode;
        c_item_next.band_slot    = b_item_reg.band_slot;
        c_item_next.band_value   = b_item_reg.band_value;
        c_item_next.loudness     = b_item_reg.loudness;
        c_item_next.bass_level   = b_item_reg.bass_level;
        c_item_next.beat_counter = b_item_reg.beat_counter;
        c_item_next.key_code     = b_item_reg.key_code;
        c_item_next.rs           = b_rs_reg;
        c_item_next.rows         = b_rows_reg;
        c_item_next.drop         = b_drops_reg;
        if (b_left_reg)
        begin
            c_item_next.idx = '0;
            c_item_next.rem = '0;
            c_item_next.cn  = '0;
        end
        else if (b_right_reg)
        begin
            c_item_next.idx = BAND_IDX_W'(BAND_COUNT - 1);
            c_item_next.rem = '0;
            c_item_next.cn  = ONE;
        end
        else
        begin
            c_item_next.idx = BAND_IDX_W'(b_idx_reg);
            c_item_next.rem = rem_full[4:0];
            c_item_next.cn  = b_cn_reg;
        end
        case (b_hsel_reg)
            H_ONE:   c_item_next.hn = ONE;
            H_DIV:   c_item_next.hn = b_hn_reg;
            default: c_item_next.hn = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_v_reg <= item_valid;
            if (b_free)
                b_v_reg <= a_v_reg;
            if (c_free)
                c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
        begin
            a_item_reg  <= item;
            a_num_reg   <= NUM_W'(off[4:0]) * NUM_W'(BAND_COUNT - 1);
            a_off_reg   <= off[4:0];
            a_span_reg  <= span;
            a_rs_reg    <= recip_tab[span];
            a_rr_reg    <= recip_tab[hdiv];
            a_drop_reg  <= drop[4:0];
            a_left_reg  <= left;
            a_right_reg <= right;
            a_hsel_reg  <= hsel;
            a_rows_reg  <= rows;
            a_drops_reg <= drop;
        end
        if (b_free)
        begin
            b_item_reg  <= a_item_reg;
            b_idx_reg   <= q_prod[RECIP_SHIFT +: IDX_W];
            b_num_reg   <= a_num_reg;
            b_span_reg  <= a_span_reg;
            b_rs_reg    <= a_rs_reg;
            b_cn_reg    <= cn_prod[RECIP_SHIFT +: 16];
            b_hn_reg    <= hn_prod[RECIP_SHIFT +: 16];
            b_left_reg  <= a_left_reg;
            b_right_reg <= a_right_reg;
            b_hsel_reg  <= a_hsel_reg;
            b_rows_reg  <= a_rows_reg;
            b_drops_reg <= a_drops_reg;
        end
        if (c_free)
            c_item_reg <= c_item_next;
    end

    assign result = c_item_reg;

endmodule

### sv/asks_band.sv
// ----------------------------------------------------------------------------
// asks_band
// Band store, frame state and beat flash; band interpolation for keys.
// ----------------------------------------------------------------------------
module asks_band #(
    parameter int BAND_COUNT = asks_pkg::BAND_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  asks_pkg::col_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output asks_pkg::band_item_t result
);
    import asks_pkg::*;

    localparam int IDX_W  = $clog2(BAND_COUNT);
    localparam int PROD_W = 20 + RECIP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BAND_COUNT - 1);

    logic d_free, e_free, f_free;
    logic d_v_reg, e_v_reg, f_v_reg;

    assign f_free       = !f_v_reg || result_ready;
    assign e_free       = !e_v_reg || f_free;
    assign d_free       = !d_v_reg || e_free;
    assign item_ready   = d_free;
    assign result_valid = f_v_reg;

    col_item_t   d_item_reg;
    logic [15:0] d_frac_reg;

    logic [PROD_W-1:0] frac_prod;
    assign frac_prod = PROD_W'({item.rem, 15'd0}) * PROD_W'(item.rs);

    // store and frame state, all updated as an item leaves stage d
    logic [15:0] band_mem [BAND_COUNT];
    logic [BAND_COUNT-1:0] band_ok_reg;
    logic [15:0] seen_beat_reg, flash_reg, loud_reg, bass_reg;

    logic [IDX_W-1:0] rd_idx, rd_nxt, slot_idx;
    logic             d_go, slot_hit, frame_hit;
    logic [15:0]      flash_decay, flash_next;

    always_comb
    begin
        rd_idx      = d_item_reg.idx[IDX_W-1:0];
        rd_nxt      = (rd_idx < LAST_IDX) ? rd_idx + 1'b1 : rd_idx;
        slot_idx    = IDX_W'(d_item_reg.band_slot);
        d_go        = d_v_reg && e_free;
        slot_hit    = d_go && (d_item_reg.mode == MODE_BAND) &&
                      (32'(d_item_reg.band_slot) < BAND_COUNT);
        frame_hit   = d_go && (d_item_reg.mode == MODE_FRAME);
        flash_decay = qmul(flash_reg, FLASH_KEEP);
        if (d_item_reg.beat_counter != seen_beat_reg)
            flash_next = ONE;
        else if (flash_decay < FLASH_MIN)
            flash_next = '0;
        else
            flash_next = flash_decay;
    end

    // stage e
    logic [15:0] e_key_reg, e_raw0_reg, e_raw1_reg, e_frac_reg;
    logic        e_ok0_reg, e_ok1_reg;
    logic [15:0] e_cn_reg, e_hn_reg, e_loud_reg, e_bass_reg, e_flash_reg;
    logic signed [6:0] e_rows_reg;
    logic signed [5:0] e_drop_reg;

    band_item_t f_item_reg, f_item_next;
    logic [15:0] b0, b1;
    logic [32:0] interp;

    always_comb
    begin
        b0     = e_ok0_reg ? e_raw0_reg : 16'd0;
        b1     = e_ok1_reg ? e_raw1_reg : 16'd0;
        interp = 33'(b0) * 33'(ONE - e_frac_reg) + 33'(b1) * 33'(e_frac_reg) + 33'd16384;
        f_item_next.key_code = e_key_reg;
        f_item_next.band     = interp[30:15];
        f_item_next.cn       = e_cn_reg;
        f_item_next.hn       = e_hn_reg;
        f_item_next.rows     = e_rows_reg;
        f_item_next.drop     = e_drop_reg;
        f_item_next.loud     = e_loud_reg;
        f_item_next.bass     = e_bass_reg;
        f_item_next.flash    = e_flash_reg;
        f_item_next.loud_sq  = qmul(e_loud_reg, e_loud_reg);
        f_item_next.glow     = qmul(e_loud_reg, GLOW_GAIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg       <= 1'b0;
            e_v_reg       <= 1'b0;
            f_v_reg       <= 1'b0;
            band_ok_reg   <= '0;
            seen_beat_reg <= '0;
            flash_reg     <= '0;
            loud_reg      <= '0;
            bass_reg      <= '0;
        end
        else
        begin
            if (d_free)
                d_v_reg <= item_valid;
            // only key transactions go on past the store
            if (e_free)
                e_v_reg <= d_v_reg && (d_item_reg.mode == MODE_KEY);
            if (f_free)
                f_v_reg <= e_v_reg;
            if (slot_hit)
                band_ok_reg[slot_idx] <= 1'b1;
            if (frame_hit)
            begin
                loud_reg      <= sat_one(d_item_reg.loudness);
                bass_reg      <= sat_one(d_item_reg.bass_level);
                seen_beat_reg <= d_item_reg.beat_counter;
                flash_reg     <= flash_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_free)
        begin
            d_item_reg <= item;
            d_frac_reg <= frac_prod[RECIP_SHIFT +: 16];
        end
        if (slot_hit)
            band_mem[slot_idx] <= sat_one(d_item_reg.band_value);
        if (e_free)
        begin
            e_raw0_reg  <= band_mem[rd_idx];
            e_raw1_reg  <= band_mem[rd_nxt];
            e_ok0_reg   <= band_ok_reg[rd_idx];
            e_ok1_reg   <= band_ok_reg[rd_nxt];
            e_key_reg   <= d_item_reg.key_code;
            e_frac_reg  <= d_frac_reg;
            e_cn_reg    <= d_item_reg.cn;
            e_hn_reg    <= d_item_reg.hn;
            e_rows_reg  <= d_item_reg.rows;
            e_drop_reg  <= d_item_reg.drop;
            e_loud_reg  <= loud_reg;
            e_bass_reg  <= bass_reg;
            e_flash_reg <= flash_reg;
        end
        if (f_free)
            f_item_reg <= f_item_next;
    end

    assign result = f_item_reg;

endmodule

### sv/asks_color.sv
// ----------------------------------------------------------------------------
// asks_color
// Effect select, hue and gradient tint, mix amount and the output register.
// ----------------------------------------------------------------------------
module asks_color (
    input  logic                 clk,
    input  logic                 rst_n,
    input  asks_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  asks_pkg::band_item_t item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output asks_pkg::out_item_t  result
);
    import asks_pkg::*;

    logic g_free, h_free, o_free;
    logic g_v_reg, h_v_reg, o_v_reg;

    assign o_free       = !o_v_reg || result_ready;
    assign h_free       = !h_v_reg || o_free;
    assign g_free       = !g_v_reg || h_free;
    assign item_ready   = g_free;
    assign result_valid = o_v_reg;

    // stage g: effect select
    logic signed [24:0] bext, rext, dext, bars_v;
    logic [15:0] bars_amt, amt, t_sel;

    always_comb
    begin
        bext   = {9'd0, item.band};
        rext   = {{18{item.rows[6]}}, item.rows};
        dext   = {{4{item.drop[5]}}, item.drop, 15'd0};
        bars_v = bext * rext - dext;
        if (bars_v < 25'sd0)
            bars_amt = '0;
        else if (bars_v > 25'sd32768)
            bars_amt = ONE;
        else
            bars_amt = bars_v[15:0];
        case (cfg.effect)
            EFF_BARS:
            begin
                amt   = bars_amt;
                t_sel = item.hn;
            end
            EFF_RAINBOW:
            begin
                amt   = qmul(item.band, item.band);
                t_sel = '0;
            end
            EFF_LEVEL:
            begin
                amt   = item.loud_sq;
                t_sel = item.loud;
            end
            default:
            begin
                amt   = (item.flash > item.glow) ? item.flash : item.glow;
                t_sel = item.bass;
            end
        endcase
        if (amt > ONE)
            amt = ONE;
        if (t_sel > ONE)
            t_sel = ONE;
    end

    logic [15:0] g_key_reg, g_hue_reg, g_t_reg, g_amt_reg;
    logic        g_rainbow_reg;

    // stage h: hue sectors and gradient
    logic [17:0] hue_s;
    logic [2:0]  sector;
    logic [15:0] hf, hq;
    logic [15:0] hc [3];
    logic [7:0]  grad [3];
    logic [7:0]  lo, hi;
    logic [23:0] gp;

    always_comb
    begin
        hue_s  = 18'(g_hue_reg[14:0]) * 18'd6;
        sector = hue_s[17:15];
        hf     = {1'b0, hue_s[14:0]};
        hq     = ONE - hf;
        case (sector)
            3'd0:
            begin
                hc[0] = ONE; hc[1] = hf;  hc[2] = '0;
            end
            3'd1:
            begin
                hc[0] = hq;  hc[1] = ONE; hc[2] = '0;
            end
            3'd2:
            begin
                hc[0] = '0;  hc[1] = ONE; hc[2] = hf;
            end
            3'd3:
            begin
                hc[0] = '0;  hc[1] = hq;  hc[2] = ONE;
            end
            3'd4:
            begin
                hc[0] = hf;  hc[1] = '0;  hc[2] = ONE;
            end
            default:
            begin
                hc[0] = ONE; hc[1] = '0;  hc[2] = hq;
            end
        endcase
        lo = '0;
        hi = '0;
        gp = '0;
        for (int c = 0; c < 3; c++)
        begin
            lo      = cfg.low_color[8*(2-c) +: 8];
            hi      = cfg.high_color[8*(2-c) +: 8];
            gp      = 24'(lo) * 24'(ONE - g_t_reg) + 24'(hi) * 24'(g_t_reg) + 24'd16384;
            grad[c] = gp[22:15];
        end
    end

    logic [15:0] h_key_reg, h_amt_reg;
    logic [15:0] h_c_reg [3];
    logic [7:0]  h_grad_reg [3];
    logic        h_rainbow_reg;

    // stage o: hue channels to bytes, or the gradient tint outside rainbow
    logic [7:0]  tint [3];
    logic [23:0] bp;
    out_item_t   o_item_next, o_item_reg;

    always_comb
    begin
        bp = '0;
        for (int c = 0; c < 3; c++)
        begin
            bp      = 24'(h_c_reg[c]) * 24'd255 + 24'd16384;
            tint[c] = h_rainbow_reg ? bp[22:15] : h_grad_reg[c];
        end
        o_item_next.out_key    = h_key_reg;
        o_item_next.tint_red   = tint[0];
        o_item_next.tint_green = tint[1];
        o_item_next.tint_blue  = tint[2];
        o_item_next.mix_amount = h_amt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (g_free)
                g_v_reg <= item_valid;
            if (h_free)
                h_v_reg <= g_v_reg;
            if (o_free)
                o_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_free)
        begin
            g_key_reg     <= item.key_code;
            g_hue_reg     <= qmul(item.cn, HUE_SPAN);
            g_t_reg       <= t_sel;
            g_amt_reg     <= amt;
            g_rainbow_reg <= (cfg.effect == EFF_RAINBOW);
        end
        if (h_free)
        begin
            h_key_reg     <= g_key_reg;
            h_amt_reg     <= g_amt_reg;
            h_rainbow_reg <= g_rainbow_reg;
            for (int c = 0; c < 3; c++)
            begin
                h_c_reg[c]    <= hc[c];
                h_grad_reg[c] <= grad[c];
            end
        end
        if (o_free)
            o_item_reg <= o_item_next;
    end

    assign result = o_item_reg;

endmodule

### sv/audio_spectrum_key_shader.sv
// ----------------------------------------------------------------------------
// audio_spectrum_key_shader
// Spectrum visualizer shader for keyboard lighting: band store, beat flash
// and per-key tint and mix amount for four effects.
// ----------------------------------------------------------------------------
// Every transaction (band load, frame header or key) enters a nine-stage
// pipeline and one can be taken on every cycle unless the output stalls;
// only keys give a result, band loads and frame headers give none.
// Stages: three for column and row geometry (reciprocal table, multiplies,
// remainder), three for the band store and frame state (fraction, store
// read, interpolation) and three for the tint (effect select, hue and
// gradient, output register). Stalls at the output collapse bubbles stage
// by stage. The band store and frame state are updated in pipeline order at
// the store stage, so every key sees all transactions taken before it.
// Registers must be written only while no transaction is in flight.
module audio_spectrum_key_shader #(
    parameter int BAND_COUNT = asks_pkg::BAND_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [23:0]         wr_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  asks_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output asks_pkg::out_item_t result
);
    import asks_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect       <= EFF_BARS;
            cfg_reg.low_color    <= 24'h000000;
            cfg_reg.high_color   <= 24'hFFFFFF;
            cfg_reg.top_row      <= 5'd0;
            cfg_reg.bottom_row   <= 5'd5;
            cfg_reg.first_column <= 5'd0;
            cfg_reg.last_column  <= 5'd21;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_EFFECT:       cfg_reg.effect       <= wr_data[1:0];
                REG_LOW_COLOR:    cfg_reg.low_color    <= wr_data;
                REG_HIGH_COLOR:   cfg_reg.high_color   <= wr_data;
                REG_TOP_ROW:      cfg_reg.top_row      <= wr_data[4:0];
                REG_BOTTOM_ROW:   cfg_reg.bottom_row   <= wr_data[4:0];
                REG_FIRST_COLUMN: cfg_reg.first_column <= wr_data[4:0];
                REG_LAST_COLUMN:  cfg_reg.last_column  <= wr_data[4:0];
                default:          ;
            endcase
        end
    end

    logic       col_valid, col_ready, band_valid, band_ready;
    col_item_t  col_item;
    band_item_t band_item;

    asks_col #(
        .BAND_COUNT(BAND_COUNT)
    ) u_col (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (col_valid),
        .result_ready (col_ready),
        .result       (col_item)
    );

    asks_band #(
        .BAND_COUNT(BAND_COUNT)
    ) u_band (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (col_valid),
        .item_ready   (col_ready),
        .item         (col_item),
        .result_valid (band_valid),
        .result_ready (band_ready),
        .result       (band_item)
    );

    asks_color u_color (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (band_valid),
        .item_ready   (band_ready),
        .item         (band_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // mix amount stays within one
    a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.mix_amount <= ONE))
        else $error("mix amount above one");

    // an empty output means every stage has room
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output");

    // a stalled result is held, not dropped, while the input is stalled too
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready && !item_ready) |=> result_valid)
        else $error("result dropped during stall");

endmodule
